[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL. Empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PILC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define PILC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PILC_ASSERT_IMP(lbl, ante, cons, msg)
`define PILC_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[hw/rtl/pilc_pkg.sv]
// ---------------------------------------------------------------------------
// pilc_pkg
// Sizes, cell command word and scan token of the path to inode cache.
// ---------------------------------------------------------------------------
package pilc_pkg;

	localparam int CE      = 8;                          // cache entries
	localparam int PB      = 64;                         // path bytes kept
	localparam int IW      = (CE > 1) ? $clog2(CE) : 1;  // entry index
	localparam int PW      = $clog2(PB);                 // byte address
	localparam int CW      = $clog2(PB + 1);             // byte count 0..PB
	localparam int NW      = $clog2(CE + 1);             // scan cycle count
	localparam int SLOT_W  = 3;
	localparam int INODE_W = 32;
	localparam int AGE_W   = 32;
	localparam int BYTE_W  = 8;

	typedef logic [IW-1:0] idx_t;

	typedef struct packed {
		logic               cmp_en;
		logic [BYTE_W-1:0]  cmp_byte;
		logic [PW-1:0]      rd_addr;
		logic               clr_match;
		logic               touch;
		logic               fill;
		logic [AGE_W-1:0]   age;
		logic [INODE_W-1:0] inode;
		logic [CW-1:0]      len;
		logic [CW-1:0]      bp_end;
		logic               we;
		logic [PW-1:0]      waddr;
		logic [BYTE_W-1:0]  wdata;
	} cell_cmd_t;

	typedef struct packed {
		logic               hit;
		idx_t               hit_idx;
		logic [INODE_W-1:0] hit_inode;
		logic               old_ok;
		logic [AGE_W-1:0]   old_age;
		idx_t               old_idx;
		logic               free_ok;
		idx_t               free_idx;
	} scan_tok_t;

	function automatic logic [SLOT_W-1:0] to_slot(input idx_t i);
		return SLOT_W'(i);
	endfunction

endpackage

[hw/rtl/pilc_cell.sv]
// ---------------------------------------------------------------------------
// pilc_cell
// One cache entry: path byte store, match flag, age, inode, and one stage of
// the scan chain that finds the first hit, the oldest entry and a free slot.
// ---------------------------------------------------------------------------
module pilc_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  pilc_pkg::idx_t      idx,
	input  pilc_pkg::cell_cmd_t cmd,
	input  logic                sel,
	input  logic                wsel,
	input  pilc_pkg::scan_tok_t tok_in,
	output pilc_pkg::scan_tok_t tok_out
);
	import pilc_pkg::*;

	logic [BYTE_W-1:0]  mem_q [PB];
	logic [BYTE_W-1:0]  rd_q;
	logic               match_q;
	logic               valid_q;
	logic [AGE_W-1:0]   age_q;
	logic [INODE_W-1:0] inode_q;
	logic [CW-1:0]      len_q;
	scan_tok_t          tok_q;
	scan_tok_t          tok_d;
	logic               hit_here;

	// read data always reflects the next byte position
	always_ff @(posedge clk) begin
		rd_q <= mem_q[cmd.rd_addr];
		if (cmd.we && wsel) begin
			mem_q[cmd.waddr] <= cmd.wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b1;
			valid_q <= 1'b0;
			age_q   <= '0;
		end else begin
			if (cmd.clr_match) begin
				match_q <= 1'b1;
			end else if (cmd.cmp_en && (rd_q != cmd.cmp_byte)) begin
				match_q <= 1'b0;
			end
			if (cmd.fill && sel) begin
				valid_q <= 1'b1;
			end
			if ((cmd.touch || cmd.fill) && sel) begin
				age_q <= cmd.age;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill && sel) begin
			inode_q <= cmd.inode;
			len_q   <= cmd.len;
		end
	end

	// stored path is zero past its length, so the tail check is a compare
	assign hit_here = valid_q && match_q && (len_q <= cmd.bp_end);

	always_comb begin
		tok_d = tok_in;
		if (!tok_in.hit && hit_here) begin
			tok_d.hit       = 1'b1;
			tok_d.hit_idx   = idx;
			tok_d.hit_inode = inode_q;
		end
		if (valid_q) begin
			if (!tok_in.old_ok || (age_q < tok_in.old_age)) begin
				tok_d.old_ok  = 1'b1;
				tok_d.old_age = age_q;
				tok_d.old_idx = idx;
			end
		end else if (!tok_in.free_ok) begin
			tok_d.free_ok  = 1'b1;
			tok_d.free_idx = idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	assign tok_out = tok_q;

endmodule

[hw/rtl/path_inode_lru_cache_top.sv]
// ---------------------------------------------------------------------------
// path_inode_lru_cache_top
// Fully associative path to inode cache with least recently stamped eviction.
// ---------------------------------------------------------------------------
// A path streams in one byte per cycle (start high while busy is low), each
// byte compared in parallel against every cached entry. The byte marked
// path_last starts a scan through the row of entry cells, one cell per cycle:
// busy stays high for the scan and done then pulses for a single cycle with
// hit, slot and found_inode. It must be taken in that cycle; there is no
// holding off. A find, or an update that hits, is finished there. An update
// that misses then copies the path into the chosen entry, one byte a cycle
// from the input buffer, and busy stays high through the copy and the drain.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module path_inode_lru_cache_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         op,
	input  logic [pilc_pkg::BYTE_W-1:0]  path_byte,
	input  logic                         path_last,
	input  logic [pilc_pkg::INODE_W-1:0] inode_value,
	output logic                         done,
	output logic                         hit,
	output logic [pilc_pkg::SLOT_W-1:0]  slot,
	output logic [pilc_pkg::INODE_W-1:0] found_inode
);
	import pilc_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_COPY  = 2'd2;
	localparam logic [1:0] S_DRAIN = 2'd3;

	logic [1:0]         state_q;
	logic [CW-1:0]      pos_q;
	logic [CW-1:0]      len_q;
	logic               zero_seen_q;
	logic [CW-1:0]      bp_end_q;
	logic [CW-1:0]      plen_q;
	logic               op_q;
	logic [INODE_W-1:0] inode_q;
	logic [NW-1:0]      scnt_q;
	logic [CW-1:0]      k_q;
	logic [CE-1:0]      vsel_q;
	logic [AGE_W-1:0]   ctr_q;
	logic [BYTE_W-1:0]  ib_q [PB];
	logic [BYTE_W-1:0]  ib_rd_s1;
	logic [PW-1:0]      k_s1;
	logic               wv_s1;
	logic               done_q;
	logic               hit_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [INODE_W-1:0] found_q;

	logic               acc;
	logic               in_rng;
	logic [BYTE_W-1:0]  bnew;
	logic [CW-1:0]      pos_inc;
	logic [CW-1:0]      len_new;
	logic [CW-1:0]      pos_d;
	logic               scan_end;
	idx_t               victim;
	idx_t               tgt;
	logic [CE-1:0]      sel;
	cell_cmd_t          cmd;
	scan_tok_t          tok [CE+1];
	scan_tok_t          tk;

	assign busy   = (state_q != S_IDLE);
	assign acc    = start && !busy;
	assign in_rng = (pos_q < CW'(PB));
	// once a zero byte is seen the rest of the path reads as zero
	assign bnew    = zero_seen_q ? '0 : path_byte;
	assign pos_inc = in_rng ? pos_q + CW'(1) : pos_q;
	assign len_new = (in_rng && (bnew != '0)) ? pos_q + CW'(1) : len_q;
	assign pos_d   = acc ? (path_last ? '0 : pos_inc) : pos_q;

	assign scan_end = (state_q == S_SCAN) && (scnt_q == NW'(CE));
	assign tk       = tok[CE];
	assign victim   = tk.free_ok ? tk.free_idx : tk.old_idx;
	assign tgt      = tk.hit ? tk.hit_idx : victim;

	always_comb begin
		cmd           = '0;
		cmd.cmp_en    = acc && in_rng;
		cmd.cmp_byte  = bnew;
		cmd.rd_addr   = pos_d[PW-1:0];
		cmd.clr_match = scan_end;
		cmd.touch     = scan_end && op_q && tk.hit;
		cmd.fill      = scan_end && op_q && !tk.hit;
		cmd.age       = ctr_q + AGE_W'(1);
		cmd.inode     = inode_q;
		cmd.len       = plen_q;
		cmd.bp_end    = bp_end_q;
		cmd.we        = wv_s1;
		cmd.waddr     = k_s1;
		cmd.wdata     = (CW'(k_s1) < plen_q) ? ib_rd_s1 : '0;
	end

	assign tok[0] = '0;

	genvar gi;
	generate
		for (gi = 0; gi < CE; gi++) begin : g_cell
			assign sel[gi] = (tgt == IW'(gi));
			pilc_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.idx     (IW'(gi)),
				.cmd     (cmd),
				.sel     (sel[gi]),
				.wsel    (vsel_q[gi]),
				.tok_in  (tok[gi]),
				.tok_out (tok[gi+1])
			);
		end
	endgenerate

	// incoming path buffer, read out during the copy into the victim
	always_ff @(posedge clk) begin
		if (acc && in_rng) begin
			ib_q[pos_q[PW-1:0]] <= bnew;
		end
		ib_rd_s1 <= ib_q[k_q[PW-1:0]];
		k_s1     <= k_q[PW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pos_q       <= '0;
			len_q       <= '0;
			zero_seen_q <= 1'b0;
			scnt_q      <= '0;
			k_q         <= '0;
			ctr_q       <= '0;
			wv_s1       <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= scan_end;
			wv_s1  <= (state_q == S_COPY);
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (path_last) begin
							pos_q       <= '0;
							len_q       <= '0;
							zero_seen_q <= 1'b0;
							scnt_q      <= '0;
							state_q     <= S_SCAN;
						end else begin
							pos_q <= pos_inc;
							len_q <= len_new;
							if (in_rng && (bnew == '0)) begin
								zero_seen_q <= 1'b1;
							end
						end
					end
				end
				S_SCAN: begin
					scnt_q <= scnt_q + NW'(1);
					if (scan_end) begin
						if (op_q) begin
							ctr_q <= ctr_q + AGE_W'(1);
						end
						k_q <= '0;
						state_q <= (op_q && !tk.hit) ? S_COPY : S_IDLE;
					end
				end
				S_COPY: begin
					k_q <= k_q + CW'(1);
					if (k_q == CW'(PB - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && path_last) begin
			bp_end_q <= pos_inc;
			plen_q   <= len_new;
			op_q     <= op;
			inode_q  <= inode_value;
		end
		if (scan_end) begin
			vsel_q  <= sel;
			hit_q   <= tk.hit;
			found_q <= tk.hit ? tk.hit_inode : '0;
			if (tk.hit) begin
				slot_q <= to_slot(tk.hit_idx);
			end else if (op_q) begin
				slot_q <= to_slot(victim);
			end else begin
				slot_q <= '0;
			end
		end
	end

	assign done        = done_q;
	assign hit         = hit_q;
	assign slot        = slot_q;
	assign found_inode = found_q;

	`PILC_ASSERT_IMP(a_done_after_scan, done, $past(scan_end), "result word without a finished scan")
	`PILC_ASSERT_NXT(a_last_starts_scan, start && !busy && path_last, busy && !done, "last byte did not start a scan")
	`PILC_ASSERT_IMP(a_copy_one_target, state_q == S_COPY, $onehot(vsel_q), "copy must target exactly one entry")
	`PILC_ASSERT_IMP(a_miss_zero_inode, done && !hit, found_inode == '0, "miss reports non-zero inode")

endmodule

[dv/path_inode_lru_cache_chk.sv]
// ---------------------------------------------------------------------------
// path_inode_lru_cache_chk
// Watches the byte stream and the result strobe of the path to inode cache.
// It keeps its own copy of the entries, ages and access count, works out
// hit, slot and inode for every path, and compares them with the block.
// ---------------------------------------------------------------------------
module path_inode_lru_cache_chk #(
	parameter logic UPDATE_OP = 1'b1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic                         op,
	input  logic [pilc_pkg::BYTE_W-1:0]  path_byte,
	input  logic                         path_last,
	input  logic [pilc_pkg::INODE_W-1:0] inode_value,
	input  logic                         done,
	input  logic                         hit,
	input  logic [pilc_pkg::SLOT_W-1:0]  slot,
	input  logic [pilc_pkg::INODE_W-1:0] found_inode,
	output int                           fail_count,
	output int                           lookups_due
);

	localparam int CE = pilc_pkg::CE;
	localparam int PB = pilc_pkg::PB;

	typedef struct packed {
		logic                         hit;
		logic [pilc_pkg::SLOT_W-1:0]  slot;
		logic [pilc_pkg::INODE_W-1:0] inode;
	} lookup_t;

	logic [pilc_pkg::BYTE_W-1:0]  entry_path [CE][PB];
	logic [pilc_pkg::INODE_W-1:0] entry_inode [CE];
	logic [pilc_pkg::AGE_W-1:0]   entry_age [CE];
	int                           entries_used;
	logic [pilc_pkg::AGE_W-1:0]   access_cnt;
	logic [pilc_pkg::BYTE_W-1:0]  rx_path [PB];
	int                           rx_pos;
	logic [CE-1:0]                still_match;
	lookup_t                      pending_lookups [$];

	task automatic clear_rx();
		for (int p = 0; p < PB; p++)
			rx_path[p] = '0;
		rx_pos = 0;
		still_match = '1;
	endtask

	task automatic clear_cache();
		for (int e = 0; e < CE; e++) begin
			for (int p = 0; p < PB; p++)
				entry_path[e][p] = '0;
			entry_inode[e] = '0;
			entry_age[e] = '0;
		end
		entries_used = 0;
		access_cnt = '0;
		clear_rx();
	endtask

	// one accepted word of the stream; the last byte yields one lookup
	task automatic absorb_path_byte(input logic op_v, input logic [7:0] b_in,
			input logic last_v, input logic [31:0] ino_v);
		logic [7:0] b;
		lookup_t    res;
		int         idx;
		logic       found;
		logic       tail_clear;
		b = b_in;
		if (rx_pos < PB) begin
			// after a NUL terminator the rest of the path reads as zero
			if (rx_pos > 0 && rx_path[rx_pos-1] == 8'h00)
				b = 8'h00;
			rx_path[rx_pos] = b;
			for (int e = 0; e < entries_used; e++)
				if (entry_path[e][rx_pos] != b)
					still_match[e] = 1'b0;
			rx_pos++;
		end
		if (last_v) begin
			res = '0;
			idx = 0;
			found = 1'b0;
			for (int e = 0; e < entries_used; e++) begin
				if (still_match[e] && !found) begin
					tail_clear = 1'b1;
					for (int p = rx_pos; p < PB; p++)
						if (entry_path[e][p] != 8'h00)
							tail_clear = 1'b0;
					if (tail_clear) begin
						found = 1'b1;
						idx = e;
					end
				end
			end
			if (op_v == UPDATE_OP) begin
				access_cnt = access_cnt + 1'b1;
				if (found) begin
					entry_age[idx] = access_cnt;
					res.inode = entry_inode[idx];
				end else begin
					if (entries_used < CE) begin
						idx = entries_used;
						entries_used++;
					end else begin
						idx = 0;
						for (int e = 1; e < CE; e++)
							if (entry_age[e] < entry_age[idx])
								idx = e;
					end
					for (int p = 0; p < PB; p++)
						entry_path[idx][p] = rx_path[p];
					entry_inode[idx] = ino_v;
					entry_age[idx] = access_cnt;
				end
			end else if (found) begin
				res.inode = entry_inode[idx];
			end
			res.hit = found;
			res.slot = idx[pilc_pkg::SLOT_W-1:0];
			pending_lookups.push_back(res);
			clear_rx();
		end
	endtask

	task automatic check_lookup();
		lookup_t want;
		if (pending_lookups.size() == 0) begin
			$display("%0t: result word with none expected: hit %0h slot %0h inode %0h",
				$time, hit, slot, found_inode);
			fail_count++;
		end else begin
			want = pending_lookups.pop_front();
			if (hit !== want.hit) begin
				$display("%0t: hit expected %0h actual %0h", $time, want.hit, hit);
				fail_count++;
			end
			if (slot !== want.slot) begin
				$display("%0t: slot expected %0h actual %0h", $time, want.slot, slot);
				fail_count++;
			end
			if (found_inode !== want.inode) begin
				$display("%0t: found_inode expected %0h actual %0h",
					$time, want.inode, found_inode);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_cache();
			pending_lookups.delete();
			fail_count = 0;
			lookups_due <= 0;
		end else begin
			if (done)
				check_lookup();
			if (start && !busy)
				absorb_path_byte(op, path_byte, path_last, inode_value);
			lookups_due <= pending_lookups.size();
		end
	end

endmodule

[dv/tb_path_inode_lru_cache_top.sv]
// ---------------------------------------------------------------------------
// tb_path_inode_lru_cache_top
// Streams paths into the path to inode cache, byte by byte, with random gaps.
// A few directed paths first, then paths drawn from a small pool larger than
// the cache so hits, refreshes and evictions all occur, with prefixes,
// NUL-terminated variants and paths that differ only past the kept length.
// ---------------------------------------------------------------------------
module tb_path_inode_lru_cache_top;

	localparam logic OP_FIND   = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	localparam int PB        = pilc_pkg::PB;
	localparam int MAX_LEN   = PB + 16;
	localparam int POOL      = 16;
	localparam int ITEMS     = 1550;
	localparam int DRAIN     = pilc_pkg::CE + pilc_pkg::PB + 16;
	localparam int LIMIT     = 1000000;

	logic                         clk;
	logic                         arst_n;
	logic                         start;
	logic                         busy;
	logic                         op;
	logic [pilc_pkg::BYTE_W-1:0]  path_byte;
	logic                         path_last;
	logic [pilc_pkg::INODE_W-1:0] inode_value;
	logic                         done;
	logic                         hit;
	logic [pilc_pkg::SLOT_W-1:0]  slot;
	logic [pilc_pkg::INODE_W-1:0] found_inode;
	int                           fail_count;
	int                           lookups_due;

	logic [7:0] pool_path [POOL][MAX_LEN];
	int         pool_len [POOL];
	logic [7:0] cur_path [MAX_LEN];
	int         cur_len;
	int         words_sent;
	int         cycle_cnt;
	logic       calm;

	path_inode_lru_cache_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.path_byte   (path_byte),
		.path_last   (path_last),
		.inode_value (inode_value),
		.done        (done),
		.hit         (hit),
		.slot        (slot),
		.found_inode (found_inode)
	);

	path_inode_lru_cache_chk #(.UPDATE_OP(OP_UPDATE)) chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.path_byte   (path_byte),
		.path_last   (path_last),
		.inode_value (inode_value),
		.done        (done),
		.hit         (hit),
		.slot        (slot),
		.found_inode (found_inode),
		.fail_count  (fail_count),
		.lookups_due (lookups_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic take_break();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (!calm && r >= 60) begin
			n = (r < 90) ? $urandom_range(1, 3) : $urandom_range(5, 30);
			start <= 1'b0;
			op <= 1'($urandom);
			path_byte <= 8'($urandom);
			path_last <= 1'($urandom);
			inode_value <= $urandom;
			repeat (n) @(posedge clk);
		end
	endtask

	// hold the word until the block takes it
	task automatic drive_word(input logic op_v, input logic [7:0] b,
			input logic last_v, input logic [31:0] ino_v);
		start <= 1'b1;
		op <= op_v;
		path_byte <= b;
		path_last <= last_v;
		inode_value <= ino_v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		words_sent++;
		take_break();
	endtask

	task automatic stream_path(input logic op_v, input logic [31:0] ino_v);
		for (int i = 0; i < cur_len; i++) begin
			if (i == cur_len - 1)
				drive_word(op_v, cur_path[i], 1'b1, ino_v);
			else
				drive_word(1'($urandom), cur_path[i], 1'b0, $urandom);
		end
	endtask

	task automatic load_path(input int n, input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2);
		cur_len = n;
		cur_path[0] = b0;
		cur_path[1] = b1;
		cur_path[2] = b2;
	endtask

	function automatic logic [7:0] path_char();
		return ($urandom_range(0, 19) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
	endfunction

	task automatic make_fresh(input int k);
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			pool_len[k] = $urandom_range(1, 12);
		else if (r < 90)
			pool_len[k] = $urandom_range(13, PB - 1);
		else
			pool_len[k] = $urandom_range(PB, MAX_LEN);
		for (int p = 0; p < MAX_LEN; p++)
			pool_path[k][p] = path_char();
	endtask

	initial begin
		int k;
		int v;
		int new_len;
		arst_n <= 1'b0;
		start <= 1'b0;
		op <= OP_FIND;
		path_byte <= '0;
		path_last <= 1'b0;
		inode_value <= '0;
		words_sent = 0;
		calm = 1'b0;
		cur_len = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty cache, fill, refresh, NUL inside, prefix, all-ones byte
		load_path(1, 8'h41, 8'h00, 8'h00);
		stream_path(OP_FIND, 32'h1234_5678);
		stream_path(OP_UPDATE, 32'hFFFF_FFFF);
		stream_path(OP_FIND, 32'h0);
		stream_path(OP_UPDATE, 32'h0);
		load_path(1, 8'h00, 8'h00, 8'h00);
		stream_path(OP_UPDATE, 32'h0);
		load_path(3, 8'h41, 8'h00, 8'hFF);
		stream_path(OP_FIND, 32'hFFFF_FFFF);
		load_path(2, 8'h41, 8'h42, 8'h00);
		stream_path(OP_FIND, 32'h0);
		load_path(2, 8'hFF, 8'h80, 8'h00);
		stream_path(OP_UPDATE, 32'h8000_0001);

		for (int i = 0; i < POOL; i++)
			make_fresh(i);
		while (words_sent < ITEMS) begin
			k = $urandom_range(0, POOL - 1);
			if ($urandom_range(0, 99) < 15)
				make_fresh(k);
			cur_len = pool_len[k];
			for (int p = 0; p < MAX_LEN; p++)
				cur_path[p] = pool_path[k][p];
			v = $urandom_range(0, 99);
			if (v < 10 && cur_len > 1) begin
				cur_len--;
			end else if (v < 20 && cur_len < MAX_LEN) begin
				// same string once the NUL is seen, then junk
				new_len = $urandom_range(cur_len + 1,
					(cur_len + 6 < MAX_LEN) ? cur_len + 6 : MAX_LEN);
				cur_path[cur_len] = 8'h00;
				for (int p = cur_len + 1; p < new_len; p++)
					cur_path[p] = 8'($urandom);
				cur_len = new_len;
			end else if (v < 30 && cur_len > PB) begin
				// differs only in bytes that get truncated
				for (int p = PB; p < cur_len; p++)
					cur_path[p] = 8'($urandom);
			end
			calm = ($urandom_range(0, 2) == 0);
			stream_path($urandom_range(0, 1) ? OP_UPDATE : OP_FIND, $urandom);
		end

		start <= 1'b0;
		@(posedge clk);
		while (lookups_due != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (fail_count == 0 && lookups_due == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
